>>> sv/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life grid generation step unit.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // default grid size
  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // field widths
  localparam int FUNC_W = 2;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POP_W  = 11;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;

  // input word
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic             cell_value;
    logic [POP_W-1:0] population;
  } out_word_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_STEP,
    ST_DRAIN,
    ST_FINISH
  } lgs_state_t;

endpackage

>>> sv/life_grid_generation_step_unit.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step_unit
// Game of life grid (B3/S23) with cell write, cell read and generation step.
//
//   channel  | ports                         | word
//   ---------+-------------------------------+-----------------------------------
//   input    | in_valid, in_stall, in_word   | func, row, col, value
//   result   | out_valid, out_stall, out_word| cell_value, population
//
// Write and read pass through the modify and finish states from accept to
// result register. Step scans with one grid RAM read per cycle, one extra row
// pass to preload the line buffer and one flush column per row.
// After reset a clearing pass zeroes every cell of the grid RAM; no word
// is accepted until its last write has landed.
// A stalled result holds in the output register; the next word can be accepted
// while it waits, but that word finishes only once the register is free.
// ----------------------------------------------------------------------------
module life_grid_generation_step_unit #(
  parameter int ROWS = lgs_pkg::ROWS_DEF,
  parameter int COLS = lgs_pkg::COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lgs_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output lgs_pkg::out_word_t out_word
);

  import lgs_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int LAW   = $clog2(COLS);
  localparam int CW    = $clog2(COLS + 1);
  localparam int RBW   = $clog2(ROWS + 1);

  // control registers
  lgs_state_t        state_r, state_nxt;
  logic [AW-1:0]     seq_addr_r, seq_addr_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [RBW-1:0]    scan_rb_r, scan_rb_nxt;
  logic [CW-1:0]     scan_c_r, scan_c_nxt;
  logic              p1_v_r, p1_v_nxt;
  logic              gw_en_r, gw_en_nxt;
  logic [POP_W-1:0]  live_total_r, live_total_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload registers
  in_word_t          op_r, op_nxt;
  logic [AW-1:0]     acc_addr_r, acc_addr_nxt;
  logic              inside_r, inside_nxt;
  logic              p1_pre_r, p1_pre_nxt;
  logic              p1_below_r, p1_below_nxt;
  logic              p1_in_r, p1_in_nxt;
  logic              p1_first_r, p1_first_nxt;
  logic [LAW-1:0]    p1_c_r, p1_c_nxt;
  logic [AW-1:0]     gw_addr_r, gw_addr_nxt;
  logic              gw_data_r, gw_data_nxt;
  logic              res_cell_r, res_cell_nxt;
  out_word_t         out_word_r, out_word_nxt;

  // memory ports
  logic [AW-1:0]     g_raddr;
  logic              g_rdata;
  logic              lw_en;
  logic [1:0]        lw_data;
  logic [1:0]        l_rdata;

  // datapath
  logic [AW-1:0]     acc_addr;
  logic              acc_inside;
  logic              below_bit;
  logic [2:0]        col_trip;
  logic              cell_next;
  logic              cell_calc;
  logic              out_free;

  // grid store, one bit per cell
  lgs_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (gw_en_r),
    .waddr (gw_addr_r),
    .wdata (gw_data_r),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  // line buffer, entry per column holds {row above, current row} of old data
  lgs_ram #(
    .WIDTH (2),
    .DEPTH (COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (p1_c_r),
    .wdata (lw_data),
    .raddr (scan_c_r[LAW-1:0]),
    .rdata (l_rdata)
  );

  // neighbor window and rule
  lgs_window u_window (
    .clk       (clk),
    .shift     (p1_v_r),
    .first     (p1_first_r),
    .col_in    (col_trip),
    .cell_next (cell_next)
  );

  // cell address of the incoming word
  assign acc_inside = (32'(in_word.row) < ROWS) && (32'(in_word.col) < COLS);
  assign acc_addr   = AW'(32'(in_word.row) * COLS + 32'(in_word.col));

  // column of old cells read back for the scan, dead outside the grid
  assign below_bit = g_rdata && p1_below_r && p1_in_r;
  assign col_trip  = p1_in_r && !p1_pre_r ? {l_rdata[1], l_rdata[0], below_bit}
                                          : {2'b00, below_bit};
  assign cell_calc = p1_v_r && !p1_pre_r && !p1_first_r;

  // line buffer rolls down one row as the scan passes
  assign lw_en   = p1_v_r && p1_in_r;
  assign lw_data = {(p1_pre_r ? 1'b0 : l_rdata[0]), below_bit};

  assign out_free = !out_valid_r || !out_stall;

  // next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    seq_addr_nxt   = seq_addr_r;
    rd_addr_nxt    = rd_addr_r;
    scan_rb_nxt    = scan_rb_r;
    scan_c_nxt     = scan_c_r;
    p1_v_nxt       = 1'b0;
    gw_en_nxt      = 1'b0;
    live_total_nxt = live_total_r;
    out_valid_nxt  = out_valid_r && out_stall;
    op_nxt         = op_r;
    acc_addr_nxt   = acc_addr_r;
    inside_nxt     = inside_r;
    p1_pre_nxt     = p1_pre_r;
    p1_below_nxt   = p1_below_r;
    p1_in_nxt      = p1_in_r;
    p1_first_nxt   = p1_first_r;
    p1_c_nxt       = p1_c_r;
    gw_addr_nxt    = gw_addr_r;
    gw_data_nxt    = gw_data_r;
    res_cell_nxt   = res_cell_r;
    out_word_nxt   = out_word_r;
    g_raddr        = rd_addr_r;
    in_stall       = 1'b1;

    unique case (state_r)
      ST_CLEAR: begin
        gw_en_nxt    = 1'b1;
        gw_addr_nxt  = seq_addr_r;
        gw_data_nxt  = 1'b0;
        seq_addr_nxt = seq_addr_r + AW'(1);
        if (seq_addr_r == AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // hold off while the last clearing write lands
        in_stall = gw_en_r;
        g_raddr  = acc_addr;
        if (in_valid && !gw_en_r) begin
          op_nxt       = in_word;
          acc_addr_nxt = acc_addr;
          inside_nxt   = acc_inside;
          if (in_word.func == FUNC_STEP) begin
            state_nxt      = ST_STEP;
            live_total_nxt = '0;
            seq_addr_nxt   = '0;
            rd_addr_nxt    = '0;
            scan_rb_nxt    = '0;
            scan_c_nxt     = '0;
          end else begin
            state_nxt = ST_MODIFY;
          end
        end
      end

      ST_MODIFY: begin
        res_cell_nxt = 1'b0;
        if (op_r.func == FUNC_WRITE && inside_r) begin
          res_cell_nxt = op_r.value;
          if (g_rdata != op_r.value) begin
            gw_en_nxt      = 1'b1;
            gw_addr_nxt    = acc_addr_r;
            gw_data_nxt    = op_r.value;
            live_total_nxt = op_r.value ? live_total_r + POP_W'(1)
                                        : live_total_r - POP_W'(1);
          end
        end else if (op_r.func == FUNC_READ && inside_r) begin
          res_cell_nxt = g_rdata;
        end
        state_nxt = ST_FINISH;
      end

      ST_STEP: begin
        // issue reads for column scan_c of the row below
        p1_v_nxt     = 1'b1;
        p1_pre_nxt   = (scan_rb_r == '0);
        p1_below_nxt = (scan_rb_r < RBW'(ROWS));
        p1_in_nxt    = (scan_c_r < CW'(COLS));
        p1_first_nxt = (scan_c_r == '0);
        p1_c_nxt     = scan_c_r[LAW-1:0];
        if (scan_rb_r < RBW'(ROWS) && scan_c_r < CW'(COLS)) begin
          rd_addr_nxt = rd_addr_r + AW'(1);
        end
        if (scan_c_r == CW'(COLS)) begin
          scan_c_nxt = '0;
          if (scan_rb_r == RBW'(ROWS)) begin
            state_nxt = ST_DRAIN;
          end else begin
            scan_rb_nxt = scan_rb_r + RBW'(1);
          end
        end else begin
          scan_c_nxt = scan_c_r + CW'(1);
        end
      end

      ST_DRAIN: begin
        res_cell_nxt = 1'b0;
        if (!p1_v_r && !gw_en_r) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.cell_value = res_cell_r;
          out_word_nxt.population = live_total_r;
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // new generation written back one cell per cycle
    if (cell_calc) begin
      gw_en_nxt      = 1'b1;
      gw_addr_nxt    = seq_addr_r;
      gw_data_nxt    = cell_next;
      seq_addr_nxt   = seq_addr_r + AW'(1);
      live_total_nxt = live_total_r + POP_W'(cell_next);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      seq_addr_r   <= '0;
      rd_addr_r    <= '0;
      scan_rb_r    <= '0;
      scan_c_r     <= '0;
      p1_v_r       <= 1'b0;
      gw_en_r      <= 1'b0;
      live_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seq_addr_r   <= seq_addr_nxt;
      rd_addr_r    <= rd_addr_nxt;
      scan_rb_r    <= scan_rb_nxt;
      scan_c_r     <= scan_c_nxt;
      p1_v_r       <= p1_v_nxt;
      gw_en_r      <= gw_en_nxt;
      live_total_r <= live_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    acc_addr_r <= acc_addr_nxt;
    inside_r   <= inside_nxt;
    p1_pre_r   <= p1_pre_nxt;
    p1_below_r <= p1_below_nxt;
    p1_in_r    <= p1_in_nxt;
    p1_first_r <= p1_first_nxt;
    p1_c_r     <= p1_c_nxt;
    gw_addr_r  <= gw_addr_nxt;
    gw_data_r  <= gw_data_nxt;
    res_cell_r <= res_cell_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // scan pipeline only runs during a step
  a_scan_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r |-> (state_r == ST_STEP || state_r == ST_DRAIN))
    else $error("scan stage active outside a step");

  // grid writes stay inside the store
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    gw_en_r |-> (32'(gw_addr_r) < CELLS))
    else $error("grid write beyond last cell");

  // grid is written only by clear, modify or scan
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    gw_en_r |-> ($past(state_r) == ST_CLEAR || $past(state_r) == ST_MODIFY ||
                 $past(state_r) == ST_STEP || $past(state_r) == ST_DRAIN))
    else $error("grid write from unexpected state");

  // a new result word only comes out of the finish state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |->
      $past(state_r) == ST_FINISH)
    else $error("result word loaded outside finish");

endmodule

>>> sv/lgs_ram.sv
// ----------------------------------------------------------------------------
// lgs_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lgs_window.sv
// ----------------------------------------------------------------------------
// lgs_window
// Three column sliding window over the old generation and the B3/S23 rule.
// ----------------------------------------------------------------------------
module lgs_window (
  input  logic       clk,
  input  logic       shift,
  input  logic       first,
  input  logic [2:0] col_in,
  output logic       cell_next
);

  // column bits are {above, center, below}
  logic [2:0] w_a_r;
  logic [2:0] w_b_r;
  logic [3:0] nbr_cnt;

  // shift in a new column, left edge sees dead cells
  always_ff @(posedge clk) begin
    if (shift) begin
      w_a_r <= first ? 3'b000 : w_b_r;
      w_b_r <= col_in;
    end
  end

  // neighbor count around the center of the middle column
  assign nbr_cnt = 4'($countones({w_a_r, w_b_r[2], w_b_r[0], col_in}));

  // birth on three, survival on two or three
  assign cell_next = (nbr_cnt == 4'd3) || (w_b_r[1] && (nbr_cnt == 4'd2));

endmodule
